[sv/id3pl_pkg.sv]
// Shared types and constants for the ID3v2 picture frame locator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package id3pl_pkg;

    localparam int POS_W        = 22;   // byte position / buffer length width
    localparam int OFS_W        = 21;   // image offset width
    localparam int LEN_W        = 22;   // image length width
    localparam int TAG_W        = 28;   // syncsafe tag size width
    localparam int FLEN_W       = 32;   // frame size width
    localparam int END_W        = 23;   // frame end offset width
    localparam int HEADER_BYTES = 10;
    localparam int PIC_MIN_SIZE = 20;
    localparam logic [7:0] SYNCSAFE_MASK = 8'h7F;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FRAME_HDR,
        PH_ENC,
        PH_MIME,
        PH_TYPE,
        PH_DESC,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        ST_PICTURE   = 3'd0,
        ST_TAG_END   = 3'd1,
        ST_ZERO_SIZE = 3'd2,
        ST_OVERRUN   = 3'd3,
        ST_SHORT     = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [OFS_W-1:0]   image_offset;
        logic [LEN_W-1:0]   image_length;
    } result_t;

    // Frame id "APIC", one byte per header offset
    function automatic logic [7:0] apic_byte(input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0: b = 8'h41;
            2'd1: b = 8'h50;
            2'd2: b = 8'h49;
            2'd3: b = 8'h43;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[sv/id3pl_parser.sv]
// Per-byte parse state and its next-state logic for the picture locator.
// Depends on id3pl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module id3pl_parser
    import id3pl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire in_item_t          item,
    input  wire logic [POS_W-1:0]  eff_size,
    output logic                   res_valid,
    output result_t                res
);

    phase_t              phase_reg,  phase_next;
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [TAG_W-1:0]    tag_reg,    tag_next;
    logic                v4_reg,     v4_next;
    logic [POS_W-1:0]    fstart_reg, fstart_next;
    logic [FLEN_W-1:0]   flen_reg,   flen_next;
    logic [END_W-1:0]    fend_reg,   fend_next;
    logic                pic_reg,    pic_next;
    logic                done_reg,   done_next;
    logic [3:0]          hcnt_reg,   hcnt_next;

    logic [7:0]          b;
    logic [TAG_W-1:0]    tag_shift;
    logic [TAG_W:0]      tag_sum;
    logic [TAG_W-1:0]    tag_clamp;
    logic [FLEN_W-1:0]   flen_base;
    logic [FLEN_W-1:0]   flen_new;
    logic [FLEN_W:0]     end_sum;
    logic [END_W-1:0]    pos1;
    logic                desc_hit;
    logic                pic_emit;

    assign b    = item.data_byte;
    assign pos1 = {1'b0, pos_reg} + END_W'(1);

    always_comb begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        v4_next     = v4_reg;
        fstart_next = fstart_reg;
        flen_next   = flen_reg;
        fend_next   = fend_reg;
        pic_next    = pic_reg;
        done_next   = done_reg;
        hcnt_next   = hcnt_reg;
        res_valid   = 1'b0;
        res.status       = ST_TAG_END;
        res.image_offset = '0;
        res.image_length = '0;
        tag_shift = {tag_reg[TAG_W-8:0], b[6:0] & SYNCSAFE_MASK[6:0]};
        tag_sum   = {1'b0, tag_shift} + (TAG_W+1)'(HEADER_BYTES);
        tag_clamp = tag_shift;
        flen_base = (hcnt_reg == 4'd4) ? '0 : flen_reg;
        flen_new  = v4_reg ? {flen_base[FLEN_W-8:0], b[6:0]} : {flen_base[FLEN_W-9:0], b};
        end_sum   = {{(FLEN_W+1-POS_W){1'b0}}, fstart_reg} + (FLEN_W+1)'(HEADER_BYTES)
                    + {1'b0, flen_new};
        desc_hit  = (phase_reg == PH_DESC) && (b == 8'h00);
        pic_emit  = desc_hit && (pos1 < fend_reg);

        if (!done_reg) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (eff_size < POS_W'(HEADER_BYTES)) begin
                        done_next  = 1'b1;
                        res_valid  = 1'b1;
                        res.status = ST_SHORT;
                    end else begin
                        if (pos_reg == POS_W'(3)) begin
                            v4_next = (b >= 8'd4);
                        end
                        if (pos_reg >= POS_W'(6) && pos_reg <= POS_W'(9)) begin
                            tag_next = tag_shift;
                        end
                        if (pos_reg == POS_W'(9)) begin
                            if (tag_sum > {{(TAG_W+1-POS_W){1'b0}}, eff_size}) begin
                                tag_clamp = TAG_W'(eff_size - POS_W'(HEADER_BYTES));
                            end
                            tag_next    = tag_clamp;
                            fstart_next = POS_W'(HEADER_BYTES);
                            if (TAG_W'(HEADER_BYTES) >= tag_clamp) begin
                                done_next  = 1'b1;
                                res_valid  = 1'b1;
                                res.status = ST_TAG_END;
                            end else begin
                                phase_next = PH_FRAME_HDR;
                                hcnt_next  = 4'd0;
                            end
                        end
                    end
                end
                PH_FRAME_HDR: begin
                    hcnt_next = hcnt_reg + 4'd1;
                    if (hcnt_reg < 4'd4) begin
                        pic_next = ((hcnt_reg == 4'd0) || pic_reg)
                                   && (b == apic_byte(hcnt_reg[1:0]));
                    end else if (hcnt_reg < 4'd8) begin
                        flen_next = flen_new;
                        if (hcnt_reg == 4'd7) begin
                            fend_next = end_sum[END_W-1:0];
                            if (flen_new == '0) begin
                                done_next  = 1'b1;
                                res_valid  = 1'b1;
                                res.status = ST_ZERO_SIZE;
                            end else if (end_sum >
                                         {{(FLEN_W+1-POS_W){1'b0}}, eff_size}) begin
                                done_next  = 1'b1;
                                res_valid  = 1'b1;
                                res.status = ST_OVERRUN;
                            end
                        end
                    end else if (hcnt_reg == 4'd9) begin
                        phase_next = (pic_reg && flen_reg > FLEN_W'(PIC_MIN_SIZE))
                                     ? PH_ENC : PH_SKIP;
                    end
                end
                default: begin
                    // frame body
                    unique case (phase_reg)
                        PH_ENC:  phase_next = PH_MIME;
                        PH_MIME: phase_next = (b == 8'h00) ? PH_TYPE : PH_MIME;
                        PH_TYPE: phase_next = PH_DESC;
                        PH_DESC: phase_next = desc_hit ? PH_SKIP : PH_DESC;
                        default: phase_next = phase_reg;
                    endcase
                    if (pic_emit) begin
                        res_valid        = 1'b1;
                        res.status       = ST_PICTURE;
                        res.image_offset = pos1[OFS_W-1:0];
                        res.image_length = LEN_W'(fend_reg - pos1);
                    end else if (pos1 == fend_reg) begin
                        fstart_next = fend_reg[POS_W-1:0];
                        if ({{(TAG_W-END_W){1'b0}}, fend_reg} < tag_reg) begin
                            phase_next = PH_FRAME_HDR;
                            hcnt_next  = 4'd0;
                        end else begin
                            done_next  = 1'b1;
                            res_valid  = 1'b1;
                            res.status = ST_TAG_END;
                        end
                    end
                end
            endcase
        end

        pos_next = (&pos_reg) ? pos_reg : pos_reg + POS_W'(1);

        if (item.last_byte) begin
            if (!res_valid && !done_next) begin
                res_valid  = 1'b1;
                res.status = (phase_next == PH_HEADER) ? ST_SHORT : ST_OVERRUN;
            end
            phase_next  = PH_HEADER;
            pos_next    = '0;
            tag_next    = '0;
            v4_next     = 1'b0;
            fstart_next = POS_W'(HEADER_BYTES);
            flen_next   = '0;
            fend_next   = '0;
            pic_next    = 1'b0;
            done_next   = 1'b0;
            hcnt_next   = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            tag_reg    <= '0;
            v4_reg     <= 1'b0;
            fstart_reg <= POS_W'(HEADER_BYTES);
            flen_reg   <= '0;
            fend_reg   <= '0;
            pic_reg    <= 1'b0;
            done_reg   <= 1'b0;
            hcnt_reg   <= 4'd0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tag_reg    <= tag_next;
            v4_reg     <= v4_next;
            fstart_reg <= fstart_next;
            flen_reg   <= flen_next;
            fend_reg   <= fend_next;
            pic_reg    <= pic_next;
            done_reg   <= done_next;
            hcnt_reg   <= hcnt_next;
        end
    end

endmodule

`default_nettype wire

[sv/id3pl_out_reg.sv]
// Result register with valid flag for the picture locator output channel.
// Depends on id3pl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module id3pl_out_reg
    import id3pl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     load,
    input  wire result_t  res_in,
    input  wire logic     take,
    output logic          free,
    output logic          valid,
    output result_t       res_out
);

    logic    valid_reg;
    result_t res_reg;

    // Room for a new result when empty or being drained this cycle
    assign free    = !valid_reg || take;
    assign valid   = valid_reg;
    assign res_out = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

[sv/id3v2_picture_frame_locator_core.sv]
// Top level of the ID3v2 picture frame locator: input register, config register,
// parser and result register. Depends on id3pl_pkg, id3pl_parser, id3pl_out_reg.
//
// Usage:
//   Input stream (s_*): one buffer byte per transaction, in order from offset 0;
//   s_tlast marks the final byte of a buffer and re-arms the parser for the next.
//   Output stream (m_*): at most one result transaction per input byte.
//   m_tuser carries the status code (picture found, tag end, zero frame size,
//   frame overrun, buffer too short); m_tdata carries image offset and length,
//   both zero unless the status is picture found.
//   cfg_wr_en/cfg_wr_data load the buffer length; write it only while no byte is in flight.
// Timing:
//   A byte lands in the input register when it is accepted and is parsed into
//   the result register once that register has room; m_tvalid rises as a result
//   is loaded there, and the result transaction completes when m_tready is high.
//   One byte per cycle sustained while the result side does not stall: the parser
//   is a single stage of counters and compares between the two registers.
// Stall / reset:
//   If m_tready is low with a result pending, the parser holds the byte in its
//   input register and s_tready drops once that register is full; nothing is
//   lost. Synchronous reset clears the valid flags and the buffer length register
//   and returns the parse state to the start of a buffer.
`timescale 1ns / 1ps
`default_nettype none

module id3v2_picture_frame_locator_core
    import id3pl_pkg::*;
#(
    parameter int unsigned MAX_BUFFER_BYTES = 2097152
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [POS_W-1:0]  cfg_wr_data,    // buffer_length
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,        // [7:0] data_byte
    input  wire logic              s_tlast,        // last_byte
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,        // [20:0] image_offset, [42:21] image_length
    output logic [2:0]             m_tuser         // [2:0] status
);

    // Buffer length clamp; wide enough for the largest allowed limit
    localparam logic [31:0] MAX_VEC = 32'(MAX_BUFFER_BYTES);

    logic [POS_W-1:0] buf_len_reg;
    logic [POS_W-1:0] eff_size;

    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     fire;
    logic     out_free;
    logic     res_valid;
    result_t  res;
    result_t  res_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_len_reg <= '0;
        end else if (cfg_wr_en) begin
            buf_len_reg <= cfg_wr_data;
        end
    end

    assign eff_size = ({{(32-POS_W){1'b0}}, buf_len_reg} < MAX_VEC)
                      ? buf_len_reg : MAX_VEC[POS_W-1:0];

    // Parse a byte whenever one is held and the result slot can take it
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.data_byte <= s_tdata;
            in_item_reg.last_byte <= s_tlast;
        end
    end

    id3pl_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_item_reg),
        .eff_size  (eff_size),
        .res_valid (res_valid),
        .res       (res)
    );

    id3pl_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire && res_valid),
        .res_in  (res),
        .take    (m_tready),
        .free    (out_free),
        .valid   (m_tvalid),
        .res_out (res_q)
    );

    assign m_tuser = res_q.status;
    assign m_tdata = {5'b0, res_q.image_length, res_q.image_offset};

endmodule

`default_nettype wire

[sv/id3pl_checker.sv]
// Port-level assertions for the picture locator result channel, bound to the top.
// Depends on id3pl_pkg and id3v2_picture_frame_locator_core.
`timescale 1ns / 1ps
`default_nettype none

module id3pl_checker
    import id3pl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic [2:0]  m_tuser
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Status codes beyond short buffer never appear
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_PICTURE) || (m_tuser == ST_TAG_END)
                     || (m_tuser == ST_ZERO_SIZE) || (m_tuser == ST_OVERRUN)
                     || (m_tuser == ST_SHORT))
        else $error("bad status code");

    // Offset and length only with a found picture
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_PICTURE) |-> (m_tdata == 48'd0))
        else $error("payload on non-picture status");

    // A reported picture always has bytes
    a_pic_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_PICTURE) |-> (m_tdata[42:21] != 22'd0)
                                              && (m_tdata[47:43] == 5'd0))
        else $error("empty picture reported");

endmodule

bind id3v2_picture_frame_locator_core id3pl_checker u_id3pl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[bench/id3pl_locator_checker.sv]
// Checker for the ID3v2 picture frame locator: tracks config writes and input
// transactions, predicts each result and compares it against the m_* stream.
// Depends on id3pl_pkg for the status codes, parse phases and result layout.
`timescale 1ns / 1ps

module id3pl_locator_checker
    import id3pl_pkg::*;
#(
    parameter int unsigned MAX_BUFFER_BYTES = 2097152
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [POS_W-1:0]  cfg_wr_data,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [47:0]       m_tdata,
    input  wire logic [2:0]        m_tuser,
    output int                     mismatch_count,
    output int                     pending_count,
    output int                     result_count,
    output int                     picture_count
);

    localparam logic [31:0] APIC_ID = 32'h4150_4943;

    // Shadow of the parser state
    logic [POS_W-1:0]  buf_len;
    phase_t            scan_phase;
    logic [POS_W-1:0]  byte_pos;
    logic [TAG_W-1:0]  tag_len;
    logic              ver4;
    logic [END_W-1:0]  frame_start;
    logic [FLEN_W-1:0] frame_len;
    logic              frame_is_apic;
    logic              scan_done;

    result_t           expected_q[$];
    result_t           want;
    result_t           got;
    int                err_n = 0;
    int                res_n = 0;
    int                pic_n = 0;

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        result_count   = 0;
        picture_count  = 0;
    end

    task automatic clear_scan();
        scan_phase    = PH_HEADER;
        byte_pos      = '0;
        tag_len       = '0;
        ver4          = 1'b0;
        frame_start   = END_W'(HEADER_BYTES);
        frame_len     = '0;
        frame_is_apic = 1'b0;
        scan_done     = 1'b0;
    endtask

    task automatic report_mismatch(input string why, input result_t exp_r, input result_t act_r);
        err_n++;
        if (err_n <= 10)
            $display("%0t: %s: expected status %0d offset %0d length %0d, %s %0d %s %0d %s %0d",
                     $time, why, exp_r.status, exp_r.image_offset, exp_r.image_length,
                     "got status", act_r.status, "offset", act_r.image_offset,
                     "length", act_r.image_length);
    endtask

    // One buffer byte through the shadow parser; queues the result it causes.
    task automatic locate_byte(input logic [7:0] b, input logic is_last);
        logic [63:0] p;
        logic [63:0] size;
        logic [63:0] fend;
        logic [63:0] k;
        logic [7:0]  id_byte;
        logic        hit;
        logic        in_body;
        result_t     r;
        p       = byte_pos;
        size    = (buf_len < MAX_BUFFER_BYTES) ? buf_len : MAX_BUFFER_BYTES;
        fend    = frame_start + HEADER_BYTES + frame_len;
        hit     = 1'b0;
        in_body = (scan_phase != PH_HEADER) && (scan_phase != PH_FRAME_HDR);
        r       = '0;
        if (!scan_done) begin
            case (scan_phase)
                PH_HEADER: begin
                    if (size < HEADER_BYTES) begin
                        scan_done = 1'b1;
                        hit       = 1'b1;
                        r.status  = ST_SHORT;
                    end else begin
                        if (p == 3)
                            ver4 = (b >= 8'd4);
                        if (p >= 6 && p <= 9)
                            tag_len = {tag_len[TAG_W-8:0], b[6:0]};
                        if (p == 9) begin
                            if (tag_len + HEADER_BYTES > size)
                                tag_len = TAG_W'(size - HEADER_BYTES);
                            frame_start = END_W'(HEADER_BYTES);
                            if (frame_start >= tag_len) begin
                                scan_done = 1'b1;
                                hit       = 1'b1;
                                r.status  = ST_TAG_END;
                            end else begin
                                scan_phase = PH_FRAME_HDR;
                            end
                        end
                    end
                end
                PH_FRAME_HDR: begin
                    k = p - frame_start;
                    if (k == 0) begin
                        frame_is_apic = 1'b1;
                        frame_len     = '0;
                    end
                    if (k < 4) begin
                        id_byte = 8'(APIC_ID >> (8 * (3 - k[1:0])));
                        if (b != id_byte)
                            frame_is_apic = 1'b0;
                    end else if (k < 8) begin
                        if (ver4)
                            frame_len = {frame_len[FLEN_W-8:0], b[6:0]};
                        else
                            frame_len = {frame_len[FLEN_W-9:0], b};
                        if (k == 7) begin
                            if (frame_len == 0) begin
                                scan_done = 1'b1;
                                hit       = 1'b1;
                                r.status  = ST_ZERO_SIZE;
                            end else if (frame_start + HEADER_BYTES + frame_len > size) begin
                                scan_done = 1'b1;
                                hit       = 1'b1;
                                r.status  = ST_OVERRUN;
                            end
                        end
                    end else if (k == 9) begin
                        scan_phase = (frame_is_apic && frame_len > PIC_MIN_SIZE) ? PH_ENC
                                                                                   : PH_SKIP;
                    end
                end
                PH_ENC:  scan_phase = PH_MIME;
                PH_MIME: if (b == 8'h00) scan_phase = PH_TYPE;
                PH_TYPE: scan_phase = PH_DESC;
                PH_DESC: begin
                    if (b == 8'h00) begin
                        scan_phase = PH_SKIP;
                        if (p + 1 < fend) begin
                            hit            = 1'b1;
                            r.status       = ST_PICTURE;
                            r.image_offset = OFS_W'(p + 1);
                            r.image_length = LEN_W'(fend - (p + 1));
                        end
                    end
                end
                default: ;
            endcase
            // last body byte of a frame: walk on or stop at the tag end
            if (in_body && !hit && p + 1 == fend) begin
                frame_start = END_W'(fend);
                if (frame_start < tag_len) begin
                    scan_phase = PH_FRAME_HDR;
                end else begin
                    scan_done = 1'b1;
                    hit       = 1'b1;
                    r.status  = ST_TAG_END;
                end
            end
        end
        if (byte_pos != {POS_W{1'b1}})
            byte_pos++;
        if (is_last) begin
            if (!hit && !scan_done) begin
                hit      = 1'b1;
                r.status = (scan_phase == PH_HEADER) ? ST_SHORT : ST_OVERRUN;
            end
            clear_scan();
        end
        if (hit) begin
            expected_q = {expected_q, r};
            if (r.status == ST_PICTURE)
                pic_n++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            buf_len = '0;
            clear_scan();
            expected_q.delete();
        end else begin
            if (cfg_wr_en)
                buf_len = cfg_wr_data;
            if (s_tvalid && s_tready)
                locate_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                res_n++;
                got.status       = status_t'(m_tuser);
                got.image_offset = m_tdata[OFS_W-1:0];
                got.image_length = m_tdata[OFS_W +: LEN_W];
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status != want.status || got.image_offset != want.image_offset ||
                        got.image_length != want.image_length)
                        report_mismatch("wrong field", want, got);
                end
            end
        end
        mismatch_count <= err_n;
        pending_count  <= expected_q.size();
        result_count   <= res_n;
        picture_count  <= pic_n;
    end

endmodule

[bench/id3v2_picture_frame_locator_core_tb.sv]
// Testbench top for id3v2_picture_frame_locator_core: builds ID3v2 buffers and
// drives them byte by byte; id3pl_locator_checker predicts and checks results.
// Depends on id3pl_pkg, the core and id3pl_locator_checker.
`timescale 1ns / 1ps

module id3v2_picture_frame_locator_core_tb;
    import id3pl_pkg::*;

    localparam int unsigned MAX_BYTES    = 2097152;
    localparam int          CYCLE_LIMIT  = 200000;  // watchdog, far above a clean run
    localparam int          TARGET_BYTES = 1450;    // random stimulus stops past this
    localparam int          HOLD_CYCLES  = 300;     // receiver back-pressure stretch
    localparam logic [31:0] APIC_ID      = 32'h4150_4943;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [POS_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata     = 8'h00;   // [7:0] data_byte
    logic              s_tlast     = 1'b0;    // last_byte
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [47:0]       m_tdata;               // [20:0] image_offset, [42:21] image_length
    logic [2:0]        m_tuser;               // [2:0] status

    int   mismatches;
    int   pending;
    int   results;
    int   pictures;
    int   cyc           = 0;
    int   bytes_sent    = 0;
    int   buffers_sent  = 0;
    int   settings_used = 0;
    logic hold_off      = 1'b0;
    bit   mid_change    = 1'b0;

    logic [7:0] tag_q[$];   // buffer under construction

    // No idling on either side inside this window of cycles.
    wire quiet = (cyc >= 1200) && (cyc < 1900);

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    id3v2_picture_frame_locator_core #(
        .MAX_BUFFER_BYTES (MAX_BYTES)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    id3pl_locator_checker #(
        .MAX_BUFFER_BYTES (MAX_BYTES)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatches),
        .pending_count  (pending),
        .result_count   (results),
        .picture_count  (pictures)
    );

    // Cycle counter doubles as the watchdog.
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cyc);
            $display("id3v2_picture_frame_locator_core_tb failed");
            $finish;
        end
    end

    // Result side: ~24% random stalls, none in the quiet window, and one long
    // hold-off so the core backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_off && (quiet || $urandom_range(99) >= 24);
    end

    initial begin : pressure
        wait (bytes_sent >= 300);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    function automatic logic [7:0] rand_byte(input int lo);
        return 8'($urandom_range(255, lo));
    endfunction

    // Appends one byte to the buffer under construction.
    function automatic void add_tag_byte(input logic [7:0] v);
        tag_q = {tag_q, v};
    endfunction

    // One input transaction, with random idle cycles ahead of it.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (!quiet && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
        if (is_last)
            buffers_sent++;
    endtask

    // Stop sending, wait until every predicted result is out, then let the
    // two-stage pipeline flush bytes that produce no result.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_buffer_length(input logic [POS_W-1:0] len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // Frame size field; syncsafe sizes may carry junk in bit 7, which the
    // core has to mask off.
    function automatic void push_size(input logic [31:0] n, input bit syncsafe);
        logic [7:0] b;
        logic       junk;
        for (int i = 3; i >= 0; i--) begin
            junk = ($urandom_range(3) == 0);
            if (syncsafe)
                b = {junk, n[7 * i +: 7]};
            else
                b = n[8 * i +: 8];
            add_tag_byte(b);
        end
    endfunction

    function automatic void add_frame(input bit v4);
        logic [7:0]  body[$];
        logic [31:0] id;
        logic [31:0] fsize;
        int          kind;
        int          n;
        kind = $urandom_range(99);
        id   = APIC_ID;
        if (kind < 56) begin
            // well-formed picture: encoding, MIME, type, description, image
            body = {body, 8'($urandom_range(3))};
            repeat ($urandom_range(6)) body = {body, rand_byte(1)};
            body = {body, 8'h00};
            body = {body, rand_byte(0)};
            repeat ($urandom_range(5)) body = {body, rand_byte(1)};
            body = {body, 8'h00};
            n = ($urandom_range(29) == 0) ? $urandom_range(300, 100) : $urandom_range(24, 1);
            repeat (n) body = {body, rand_byte(0)};
            while (body.size() <= PIC_MIN_SIZE)
                body = {body, rand_byte(0)};
        end else if (kind < 64) begin
            // APIC too small to be parsed
            repeat ($urandom_range(PIC_MIN_SIZE, 1)) body = {body, rand_byte(0)};
        end else if (kind < 72) begin
            // APIC that leaves no image bytes
            body = {body, 8'h00};
            repeat (PIC_MIN_SIZE) body = {body, rand_byte(1)};
            case ($urandom_range(2))
                0: begin    // description terminator is the last frame byte
                    body = {body, 8'h00};
                    body = {body, rand_byte(0)};
                    body = {body, 8'h00};
                end
                1: begin    // description runs into the frame end
                    body = {body, 8'h00};
                    body = {body, rand_byte(0)};
                    repeat ($urandom_range(4, 1)) body = {body, rand_byte(1)};
                end
                default: ;  // MIME type runs into the frame end
            endcase
        end else begin
            // other frame ids, some one bit away from APIC
            if ($urandom_range(1) == 0)
                id = APIC_ID ^ (32'h1 << $urandom_range(31));
            else
                id = $urandom;
            repeat ($urandom_range(30, 1)) body = {body, rand_byte(0)};
        end
        fsize = body.size();
        if (kind >= 94 && kind < 97)
            fsize = '0;                                          // zero-size frame
        else if (kind >= 97)
            fsize = $urandom_range(32'h0FFF_FFFF, 32'h0020_0000);  // overruns any buffer
        for (int i = 3; i >= 0; i--)
            add_tag_byte(id[8 * i +: 8]);
        push_size(fsize, v4);
        add_tag_byte(rand_byte(0));
        add_tag_byte(rand_byte(0));
        foreach (body[i])
            add_tag_byte(body[i]);
    endfunction

    // Whole ID3v2 tag into tag_q: header, 1..3 frames, maybe zero padding.
    function automatic void build_tag();
        logic [7:0]       ver;
        logic [TAG_W-1:0] hdr_size;
        logic             junk;
        int               roll;
        int               tsz;
        tag_q.delete();
        roll = $urandom_range(99);
        ver  = (roll < 45) ? 8'd4 : (roll < 90) ? 8'd3 : rand_byte(0);
        add_tag_byte(8'h49);
        add_tag_byte(8'h44);
        add_tag_byte(8'h33);
        add_tag_byte(ver);
        add_tag_byte(8'h00);
        add_tag_byte(rand_byte(0));
        repeat (4) add_tag_byte(8'h00);
        repeat ($urandom_range(3, 1)) add_frame(ver >= 8'd4);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(12, 1)) add_tag_byte(8'h00);
        tsz  = tag_q.size() - HEADER_BYTES;
        roll = $urandom_range(9);
        if (roll == 0)
            tsz = $urandom_range(tsz);            // tag ends among its frames
        else if (roll == 1)
            tsz = tsz + $urandom_range(40, 1);    // tag claims more than is there
        hdr_size = TAG_W'(tsz);
        if (roll == 2)
            hdr_size = TAG_W'($urandom);          // huge, gets clamped
        for (int j = 0; j < 4; j++) begin
            junk         = ($urandom_range(3) == 0);
            tag_q[6 + j] = {junk, hdr_size[7 * (3 - j) +: 7]};
        end
    endfunction

    // Sends count bytes of tag_q (random filler past its end), tlast on the
    // final one. At split_at the stream pauses and buffer_length changes.
    task automatic send_buffer(input int count, input int split_at,
                               input logic [POS_W-1:0] new_len);
        for (int i = 0; i < count; i++) begin
            if (i == split_at)
                set_buffer_length(new_len);
            send_byte((i < tag_q.size()) ? tag_q[i] : rand_byte(0), i == count - 1);
        end
    endtask

    initial begin : stimulus
        logic [POS_W-1:0] len_cfg;
        logic [POS_W-1:0] new_len;
        int               count;
        int               split;
        int               nbuf;
        int               roll;
        int               w;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // buffer_length is zero from reset: short buffer on the first byte,
        // the remaining bytes are ignored up to tlast
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);

        set_buffer_length(POS_W'(HEADER_BYTES));
        // all-ones header: tag size clamps to zero, tag end on the tlast byte
        for (int i = 0; i < HEADER_BYTES; i++)
            send_byte(8'hFF, i == HEADER_BYTES - 1);
        // tlast while still inside the header
        for (int i = 0; i < 4; i++)
            send_byte(rand_byte(0), i == 3);
        // all-zero header, tag size zero
        for (int i = 0; i < HEADER_BYTES; i++)
            send_byte(8'h00, i == HEADER_BYTES - 1);

        // Random part: groups of buffers sharing one buffer_length setting, but one buffer changes it partway.
        while (bytes_sent < TARGET_BYTES) begin
            build_tag();
            roll = $urandom_range(9);
            if (roll < 8) begin
                len_cfg = POS_W'(tag_q.size() + $urandom_range(6));
            end else begin
                case ($urandom_range(5))
                    0:       len_cfg = {POS_W{1'b1}};
                    1:       len_cfg = POS_W'(MAX_BYTES);
                    2:       len_cfg = POS_W'(MAX_BYTES - 1);
                    3:       len_cfg = '0;
                    4:       len_cfg = POS_W'(HEADER_BYTES - 1);
                    default: len_cfg = POS_W'(HEADER_BYTES);
                endcase
            end
            set_buffer_length(len_cfg);
            nbuf = $urandom_range(4, 1);
            for (int b = 0; b < nbuf; b++) begin
                if (b > 0)
                    build_tag();
                // huge settings cannot be filled: stop a little past the tag
                if (len_cfg > tag_q.size() + 16)
                    count = tag_q.size() + $urandom_range(8);
                else
                    count = len_cfg;
                if (count == 0)
                    count = $urandom_range(12, 1);
                roll = $urandom_range(19);
                if (roll < 2)
                    count = $urandom_range(count, 1);       // early tlast
                else if (roll == 2)
                    count = count + $urandom_range(5, 1);   // bytes past the buffer end
                split   = -1;
                new_len = len_cfg;
                if (!mid_change && count > 14 && buffers_sent >= 6) begin
                    split      = $urandom_range(count - 1, 11);
                    new_len    = POS_W'($urandom_range(80, 10));
                    mid_change = 1'b1;
                end
                send_buffer(count, split, new_len);
            end
        end

        // Wind down: wait for outstanding results, then a few idle cycles to
        // catch anything extra.
        s_tvalid <= 1'b0;
        for (w = 0; w < 4000 && pending != 0; w++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (pending != 0)
            $display("%0d predicted results never arrived", pending);
        $display("Streamed %0d bytes in %0d buffers over %0d buffer_length writes.",
                 bytes_sent, buffers_sent, settings_used);
        $display("Checked %0d results (%0d pictures located), %0d mismatches.",
                 results, pictures, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("id3v2_picture_frame_locator_core_tb passed");
        else
            $display("id3v2_picture_frame_locator_core_tb failed");
        $finish;
    end

endmodule

[filelist.f]
sv/id3pl_pkg.sv
sv/id3pl_parser.sv
sv/id3pl_out_reg.sv
sv/id3v2_picture_frame_locator_core.sv
sv/id3pl_checker.sv
bench/id3pl_locator_checker.sv
bench/id3v2_picture_frame_locator_core_tb.sv
